// ===== rtl/rc_drive_state_tracker_macros.svh =====
// Assertion macros used by the drive state tracker top level.
`ifndef RC_DRIVE_STATE_TRACKER_MACROS_SVH
`define RC_DRIVE_STATE_TRACKER_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define RCDS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RCDS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/rcds_pkg.sv =====
// Types and constants of the drive state tracker.
`default_nettype none

package rcds_pkg;

	localparam logic [11:0] NEUTRAL_HIGH_US = 12'd1550;
	localparam logic [11:0] NEUTRAL_LOW_US  = 12'd1450;
	localparam logic [11:0] GEAR_FWD_US     = 12'd1700;
	localparam logic [11:0] GEAR_REV_US     = 12'd1300;
	localparam logic [31:0] DRAG_BRAKE_MS   = 32'd3000;
	localparam logic [31:0] MS_PER_S        = 32'd1000;

	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_ESC_MODE     = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_PARK_TIMEOUT = 1'b1;

	localparam logic [1:0] MODE_CRAWLER  = 2'd0;
	localparam logic [1:0] MODE_STANDARD = 2'd1;
	localparam logic [1:0] MODE_REAL_CAR = 2'd2;
	localparam logic [1:0] MODE_NONE     = 2'd3;

	typedef struct packed {
		logic driving;
		logic reversing;
		logic braking;
		logic standing;
		logic parked;
	} rcds_flags_t;

	typedef struct packed {
		rcds_flags_t flags;
		logic [31:0] stop_time_ms;
		logic [31:0] last_motion_ms;
		logic        reverse_locked;
	} rcds_state_t;

	typedef struct packed {
		logic [1:0]  esc_mode;
		logic        park_en;
		logic [31:0] park_limit_ms;
	} rcds_cfg_t;

endpackage

`default_nettype wire

// ===== rtl/rcds_update.sv =====
// Next-state logic of the drive state tracker for one input word.
`default_nettype none

module rcds_update (
	input  wire rcds_pkg::rcds_cfg_t   cfg,
	input  wire rcds_pkg::rcds_state_t cur,
	input  wire logic [11:0]           throttle_us,
	input  wire logic [11:0]           steering_us,
	input  wire logic [11:0]           gear_us,
	input  wire logic [31:0]           now_ms,
	output rcds_pkg::rcds_state_t      nxt
);
	import rcds_pkg::*;

	logic        fwd;
	logic        back;
	logic        active;
	logic        gear_fwd;
	logic        gear_rev;
	logic [31:0] since_motion;
	logic [31:0] since_stop;
	rcds_state_t n;

	assign fwd          = throttle_us > NEUTRAL_HIGH_US;
	assign back         = throttle_us < NEUTRAL_LOW_US;
	assign active       = fwd || back || steering_us > NEUTRAL_HIGH_US
		|| steering_us < NEUTRAL_LOW_US;
	assign gear_fwd     = gear_us > GEAR_FWD_US;
	assign gear_rev     = gear_us < GEAR_REV_US;
	assign since_motion = now_ms - cur.last_motion_ms;
	assign since_stop   = now_ms - cur.stop_time_ms;

	always_comb begin
		n = cur;
		// Stick activity restarts the motion timer, so the park check can only
		// fire on a word without activity.
		if (active) begin
			n.last_motion_ms = now_ms;
			n.flags.parked   = 1'b0;
		end else if (cfg.park_en && since_motion > cfg.park_limit_ms) begin
			n.flags.parked  = 1'b1;
			n.flags.braking = 1'b0;
		end

		case (cfg.esc_mode)
			MODE_CRAWLER: begin
				if (fwd) begin
					n.flags.driving   = 1'b1;
					n.flags.reversing = 1'b0;
					n.flags.braking   = 1'b0;
					n.flags.standing  = 1'b0;
				end else if (back) begin
					n.flags.driving   = 1'b0;
					n.flags.reversing = 1'b1;
					n.flags.braking   = 1'b0;
					n.flags.standing  = 1'b0;
				end else if (!n.flags.standing) begin
					// Just stopped: drag brake on, timer starts now.
					n.flags.driving   = 1'b0;
					n.flags.reversing = 1'b0;
					n.flags.braking   = 1'b1;
					n.flags.standing  = 1'b1;
					n.stop_time_ms    = now_ms;
				end else if (n.flags.braking && since_stop > DRAG_BRAKE_MS) begin
					n.flags.braking = 1'b0;
				end
			end
			MODE_STANDARD: begin
				if (fwd) begin
					n.flags.driving   = 1'b1;
					n.flags.reversing = 1'b0;
					n.flags.braking   = 1'b0;
					n.flags.standing  = 1'b0;
					n.reverse_locked  = 1'b1;
				end else if (back) begin
					n.flags.driving   = 1'b0;
					n.flags.reversing = !cur.reverse_locked;
					n.flags.braking   = cur.reverse_locked;
					n.flags.standing  = 1'b0;
				end else begin
					n.flags.driving   = 1'b0;
					n.flags.reversing = 1'b0;
					n.flags.standing  = 1'b1;
					if (n.flags.braking) begin
						n.flags.braking  = 1'b0;
						n.reverse_locked = 1'b0;
					end
				end
			end
			MODE_REAL_CAR: begin
				n.flags.driving   = fwd && gear_fwd;
				n.flags.reversing = fwd && !gear_fwd && gear_rev;
				n.flags.braking   = !fwd && back;
				n.flags.standing  = !fwd && !back;
			end
			default: begin
			end
		endcase
	end

	assign nxt = n;

endmodule

`default_nettype wire

// ===== rtl/rc_drive_state_tracker.sv =====
// Top level of the drive state tracker: handshakes, registers and config.
`default_nettype none

`include "rc_drive_state_tracker_macros.svh"

// The tracker takes one word per cycle while in_ready is high, each holding
// throttle, steering and gear-switch pulse widths in microseconds and a
// free-running millisecond timestamp, and returns one word of five vehicle
// flags (driving, reversing, braking, standing, parked) as they stand after
// that input. An accepted word is captured in an input register; once the
// result register is empty or being emptied, a single pass of combinational
// logic updates the vehicle state and loads the result register, so the
// throughput is one word per clock while the receiver keeps up, limited only
// by that one update stage. The input register can take one more word
// while a finished result waits at the output; in_ready is low only while
// both registers hold a word and the receiver is not ready. Register 0
// selects the ESC mode (crawler drag brake, double-tap reverse, gear switch,
// or none) and register 1 the park timeout in seconds, zero disabling
// parking; the timeout is scaled to milliseconds when written. Write the
// registers only while the block is idle. All time differences wrap modulo 2^32.
module rc_drive_state_tracker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rcds_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [rcds_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [11:0]                       throttle_us,
	input  wire logic [11:0]                       steering_us,
	input  wire logic [11:0]                       gear_us,
	input  wire logic [31:0]                       now_ms,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic                                   is_driving,
	output logic                                   is_reversing,
	output logic                                   is_braking,
	output logic                                   is_standing,
	output logic                                   is_parked
);
	import rcds_pkg::*;

	// Input register.
	logic        valid_s1;
	logic [11:0] throttle_s1;
	logic [11:0] steering_s1;
	logic [11:0] gear_s1;
	logic [31:0] now_s1;

	// Configuration, vehicle state and result register.
	rcds_cfg_t   cfg_q;
	rcds_state_t state_q;
	rcds_state_t state_next;
	rcds_flags_t out_flags_q;
	logic        out_valid_q;

	logic        advance;
	logic        update;
	logic        flag_conflict;

	// The input stage moves on when the result register is empty or is
	// being emptied in this cycle.
	assign advance  = !out_valid_q || out_ready;
	assign update   = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.esc_mode      <= MODE_CRAWLER;
			cfg_q.park_en       <= 1'b0;
			cfg_q.park_limit_ms <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ESC_MODE: begin
					cfg_q.esc_mode <= cfg_wdata[1:0];
				end
				REG_PARK_TIMEOUT: begin
					cfg_q.park_en       <= cfg_wdata != '0;
					cfg_q.park_limit_ms <= 32'(cfg_wdata) * MS_PER_S;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			throttle_s1 <= throttle_us;
			steering_s1 <= steering_us;
			gear_s1     <= gear_us;
			now_s1      <= now_ms;
		end
	end

	rcds_update u_update (
		.cfg         (cfg_q),
		.cur         (state_q),
		.throttle_us (throttle_s1),
		.steering_us (steering_s1),
		.gear_us     (gear_s1),
		.now_ms      (now_s1),
		.nxt         (state_next)
	);

	// The vehicle state is control state and clears on reset: standing is
	// the only flag that starts high.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.flags.driving   <= 1'b0;
			state_q.flags.reversing <= 1'b0;
			state_q.flags.braking   <= 1'b0;
			state_q.flags.standing  <= 1'b1;
			state_q.flags.parked    <= 1'b0;
			state_q.stop_time_ms    <= '0;
			state_q.last_motion_ms  <= '0;
			state_q.reverse_locked  <= 1'b0;
		end else if (update) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			out_flags_q <= state_next.flags;
		end
	end

	assign out_valid    = out_valid_q;
	assign is_driving   = out_flags_q.driving;
	assign is_reversing = out_flags_q.reversing;
	assign is_braking   = out_flags_q.braking;
	assign is_standing  = out_flags_q.standing;
	assign is_parked    = out_flags_q.parked;

	// Driving never coexists with reversing or standing.
	assign flag_conflict = state_q.flags.driving
		&& (state_q.flags.reversing || state_q.flags.standing);

	`RCDS_ASSERT(a_flags_exclusive, !flag_conflict, "driving flag conflicts with another flag")
	`RCDS_ASSERT(a_ready_when_free, out_valid_q || in_ready, "input stalled with empty result")
	`RCDS_ASSERT_NEXT(a_state_holds, !update, $stable(state_q), "state changed without an update")
	`RCDS_ASSERT_NEXT(a_result_follows, update, out_valid_q, "updated word missed the result")

endmodule

`default_nettype wire

// ===== bench/tb_rc_drive_state_tracker.sv =====
// Self-checking testbench for the RC drive state tracker.
`timescale 1ns / 100ps

module tb_rc_drive_state_tracker;
	import rcds_pkg::*;

	// The clock period is 12 ns. A run that is still going after this many
	// cycles is hung. The slowest correct run is about 925 words, each with
	// the longest random gap and stall, plus one long hold and a few idle waits.
	localparam int RUN_LIMIT = 200_000;
	localparam int PHASE_WORDS = 90;
	localparam int PHASES = 10;

	// One row of the directed script. Each row states the register setting
	// it runs under. Where typed is set, the flag word is written out by hand.
	// Otherwise the predictor supplies it.
	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] park_s;
		logic [11:0] thr;
		logic [11:0] ste;
		logic [11:0] gear;
		logic [31:0] now;
		logic        typed;
		rcds_flags_t flags;
	} drive_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [11:0]           throttle_us;
	logic [11:0]           steering_us;
	logic [11:0]           gear_us;
	logic [31:0]           now_ms;
	logic                  out_valid;
	logic                  out_ready;
	logic                  is_driving;
	logic                  is_reversing;
	logic                  is_braking;
	logic                  is_standing;
	logic                  is_parked;

	// This is the predictor's own copy of the vehicle state and registers.
	rcds_flags_t veh;
	logic [31:0] stop_ms;
	logic [31:0] motion_ms;
	logic        rev_lock;
	logic [1:0]  esc_mode_cfg;
	logic [15:0] park_s_cfg;

	// These are the flag words still owed by the block, oldest first.
	rcds_flags_t flags_due [$];

	int err_count = 0;
	int words_sent = 0;
	int words_checked = 0;
	int cycle_count = 0;

	// Both sides share these. idle_on enables the random gaps and stalls.
	// A nonzero hold_req asks the receiver for one long hold.
	bit idle_on = 1'b1;
	int hold_req = 0;

	// Each bit of the flag word is named for mismatch reports.
	string flag_name [5] = '{"is_parked", "is_standing", "is_braking",
		"is_reversing", "is_driving"};

	// The register settings of the random phases. Every mode appears, and
	// the park timeout reaches both of its ends.
	logic [1:0] mode_plan [PHASES] = '{MODE_STANDARD, MODE_CRAWLER, MODE_REAL_CAR,
		MODE_NONE, MODE_CRAWLER, MODE_STANDARD, MODE_REAL_CAR, MODE_CRAWLER,
		MODE_NONE, MODE_STANDARD};
	logic [15:0] park_plan [PHASES] = '{16'd0, 16'd2, 16'd1, 16'd65535, 16'd0,
		16'd3, 16'd65535, 16'd1, 16'd2, 16'd5};

	// The directed script. The first rows run under the reset setting, in
	// crawler mode with parking off, where each flag word can be worked out
	// by hand. They cover the field extremes, both edges of the neutral band
	// and the drag brake at exactly 3000 ms and one past it.
	// Standard mode then runs the double push back. Real-car mode covers
	// each gear edge and the park limit at exactly 1000 ms and one past it.
	// Mode none with the longest timeout crosses the wrap of the timestamp.
	drive_row_t script [25] = '{
		'{MODE_CRAWLER, 16'd0, 12'd1500, 12'd1500, 12'd1500, 32'd0, 1'b1, 5'b00010},
		'{MODE_CRAWLER, 16'd0, 12'd4095, 12'd0, 12'd0, 32'd100, 1'b1, 5'b10000},
		'{MODE_CRAWLER, 16'd0, 12'd1500, 12'd1500, 12'd4095, 32'd200, 1'b1, 5'b00110},
		'{MODE_CRAWLER, 16'd0, 12'd1500, 12'd1500, 12'd1500, 32'd3200, 1'b1, 5'b00110},
		'{MODE_CRAWLER, 16'd0, 12'd1500, 12'd1500, 12'd1500, 32'd3201, 1'b1, 5'b00010},
		'{MODE_CRAWLER, 16'd0, 12'd0, 12'd4095, 12'd1500, 32'd3300, 1'b1, 5'b01000},
		'{MODE_CRAWLER, 16'd0, 12'd1450, 12'd1550, 12'd1500, 32'd3400, 1'b1, 5'b00110},
		'{MODE_CRAWLER, 16'd0, 12'd1551, 12'd1449, 12'd1500, 32'd3500, 1'b1, 5'b10000},
		'{MODE_CRAWLER, 16'd0, 12'd1449, 12'd1500, 12'd1500, 32'd3600, 1'b1, 5'b01000},
		'{MODE_STANDARD, 16'd0, 12'd2000, 12'd1500, 12'd1500, 32'd4000, 1'b0, 5'b0},
		'{MODE_STANDARD, 16'd0, 12'd1000, 12'd1500, 12'd1500, 32'd4100, 1'b0, 5'b0},
		'{MODE_STANDARD, 16'd0, 12'd1500, 12'd1500, 12'd1500, 32'd4200, 1'b0, 5'b0},
		'{MODE_STANDARD, 16'd0, 12'd1000, 12'd1500, 12'd1500, 32'd4300, 1'b0, 5'b0},
		'{MODE_STANDARD, 16'd0, 12'd1500, 12'd1500, 12'd1500, 32'd4400, 1'b0, 5'b0},
		'{MODE_REAL_CAR, 16'd1, 12'd2000, 12'd1500, 12'd1800, 32'd5000, 1'b0, 5'b0},
		'{MODE_REAL_CAR, 16'd1, 12'd2000, 12'd1500, 12'd1000, 32'd5100, 1'b0, 5'b0},
		'{MODE_REAL_CAR, 16'd1, 12'd2000, 12'd1500, 12'd1500, 32'd5200, 1'b0, 5'b0},
		'{MODE_REAL_CAR, 16'd1, 12'd2000, 12'd1500, 12'd1300, 32'd5300, 1'b0, 5'b0},
		'{MODE_REAL_CAR, 16'd1, 12'd2000, 12'd1500, 12'd1701, 32'd5400, 1'b0, 5'b0},
		'{MODE_REAL_CAR, 16'd1, 12'd1000, 12'd1500, 12'd1500, 32'd6000, 1'b0, 5'b0},
		'{MODE_REAL_CAR, 16'd1, 12'd1500, 12'd1500, 12'd1500, 32'd7000, 1'b0, 5'b0},
		'{MODE_REAL_CAR, 16'd1, 12'd1500, 12'd1500, 12'd1500, 32'd7001, 1'b0, 5'b0},
		'{MODE_NONE, 16'd65535, 12'd2000, 12'd1500, 12'd1500, 32'hFFF0_0000, 1'b0, 5'b0},
		'{MODE_NONE, 16'd65535, 12'd1500, 12'd1500, 12'd1500, 32'd64486424, 1'b0, 5'b0},
		'{MODE_NONE, 16'd65535, 12'd1500, 12'd1500, 12'd1500, 32'd64486425, 1'b0, 5'b0}
	};

	rc_drive_state_tracker uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_addr     (cfg_addr),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.throttle_us  (throttle_us),
		.steering_us  (steering_us),
		.gear_us      (gear_us),
		.now_ms       (now_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.is_driving   (is_driving),
		.is_reversing (is_reversing),
		.is_braking   (is_braking),
		.is_standing  (is_standing),
		.is_parked    (is_parked)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Advances the predicted vehicle state by one accepted word and returns
	// the flags as they stand afterward. Stick activity and the park check
	// come first. The selected mode runs after them. All time differences
	// are plain 32-bit subtraction, so a wrapped timestamp is handled.
	function automatic rcds_flags_t track_drive(logic [11:0] thr, logic [11:0] ste,
			logic [11:0] gear, logic [31:0] now);
		logic        fwd;
		logic        back;
		logic        gear_fwd;
		logic        gear_rev;
		logic [31:0] park_ms;
		fwd = thr > NEUTRAL_HIGH_US;
		back = thr < NEUTRAL_LOW_US;
		park_ms = {16'd0, park_s_cfg} * MS_PER_S;
		if (fwd || back || ste > NEUTRAL_HIGH_US || ste < NEUTRAL_LOW_US) begin
			motion_ms = now;
			veh.parked = 1'b0;
		end
		if (park_s_cfg != 16'd0 && (now - motion_ms) > park_ms) begin
			veh.parked = 1'b1;
			veh.braking = 1'b0;
		end
		case (esc_mode_cfg)
			MODE_CRAWLER: begin
				if (fwd) begin
					{veh.driving, veh.reversing, veh.braking, veh.standing} = 4'b1000;
				end else if (back) begin
					{veh.driving, veh.reversing, veh.braking, veh.standing} = 4'b0100;
				end else begin
					// The drag brake engages when the car stops. It is
					// released once more than 3 s have passed.
					if (!veh.standing) begin
						{veh.driving, veh.reversing, veh.braking, veh.standing} = 4'b0011;
						stop_ms = now;
					end
					if (veh.braking && (now - stop_ms) > DRAG_BRAKE_MS)
						veh.braking = 1'b0;
				end
			end
			MODE_STANDARD: begin
				if (fwd) begin
					{veh.driving, veh.reversing, veh.braking, veh.standing} = 4'b1000;
					rev_lock = 1'b1;
				end else if (back) begin
					// After a forward push, the first push back only brakes.
					if (rev_lock)
						{veh.driving, veh.reversing, veh.braking, veh.standing} = 4'b0010;
					else
						{veh.driving, veh.reversing, veh.braking, veh.standing} = 4'b0100;
				end else begin
					veh.driving = 1'b0;
					veh.reversing = 1'b0;
					veh.standing = 1'b1;
					if (veh.braking) begin
						veh.braking = 1'b0;
						rev_lock = 1'b0;
					end
				end
			end
			MODE_REAL_CAR: begin
				if (fwd) begin
					gear_fwd = gear > GEAR_FWD_US;
					gear_rev = gear < GEAR_REV_US;
					{veh.driving, veh.reversing, veh.braking, veh.standing} =
						{gear_fwd, !gear_fwd && gear_rev, 2'b00};
				end else if (back) begin
					{veh.driving, veh.reversing, veh.braking, veh.standing} = 4'b0010;
				end else begin
					{veh.driving, veh.reversing, veh.braking, veh.standing} = 4'b0001;
				end
			end
			default: begin
				// In mode none only the activity and park logic above applies.
			end
		endcase
		return veh;
	endfunction

	// Offers one word after the sender's random gap and holds it until it is
	// accepted. The expected flag word is queued at acceptance. It is the
	// typed-in value where one is given, and the prediction otherwise. The
	// predictor runs either way so that its state keeps pace with the block.
	task automatic send_word(input logic [11:0] thr, input logic [11:0] ste,
			input logic [11:0] gear, input logic [31:0] now,
			input logic typed, input rcds_flags_t typed_flags);
		int          gap;
		rcds_flags_t predicted;
		gap = idle_on ? $urandom_range(0, 17) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		throttle_us <= thr;
		steering_us <= ste;
		gear_us <= gear;
		now_ms <= now;
		do @(posedge clk); while (!in_ready);
		predicted = track_drive(thr, ste, gear, now);
		flags_due.push_back(typed ? typed_flags : predicted);
		words_sent++;
	endtask

	// Stops offering words, waits until every owed flag word has arrived,
	// and then waits on so that the two-stage pipeline is clear.
	task automatic drain();
		in_valid <= 1'b0;
		while (flags_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Writes both registers on back-to-back cycles. Call this only when the
	// block is idle.
	task automatic apply_setting(input logic [1:0] mode, input logic [15:0] secs);
		cfg_we <= 1'b1;
		cfg_addr <= REG_ESC_MODE;
		cfg_wdata <= CFG_DATA_W'(mode);
		@(posedge clk);
		cfg_addr <= REG_PARK_TIMEOUT;
		cfg_wdata <= secs;
		@(posedge clk);
		cfg_we <= 1'b0;
		esc_mode_cfg = mode;
		park_s_cfg = secs;
	endtask

	// Receiver. For each word it stalls for a random number of cycles, or
	// for one long stretch when asked. During the long hold the sender keeps
	// offering words, so the pipeline fills and in_ready must drop.
	initial begin : sink
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req > 0) begin
				stall = hold_req;
				hold_req = 0;
			end else begin
				stall = idle_on ? $urandom_range(0, 17) : 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Checks every accepted flag word against the oldest expectation. Each
	// flag is compared and reported on its own.
	always @(posedge clk) begin : check_flags
		rcds_flags_t seen;
		rcds_flags_t want;
		if (arst_n && out_valid && out_ready) begin
			seen = {is_driving, is_reversing, is_braking, is_standing, is_parked};
			if (flags_due.size() == 0) begin
				err_count++;
				$display("%0t ns: flag word arrived with none expected, actual %b",
					$time, seen);
			end else begin
				want = flags_due.pop_front();
				words_checked++;
				for (int k = 0; k < 5; k++) begin
					if (seen[k] !== want[k]) begin
						err_count++;
						$display("%0t ns: %s expected %b actual %b", $time,
							flag_name[k], want[k], seen[k]);
					end
				end
			end
		end
	end

	// Watchdog for a hung handshake or a flag word that never arrives.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > RUN_LIMIT) begin
			$display("Run stopped by the watchdog after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin : stimulus
		int          r;
		int          stick;
		int          run_left;
		logic [11:0] thr;
		logic [11:0] ste;
		logic [11:0] gear;
		logic [31:0] clock_ms;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		throttle_us = 12'd1500;
		steering_us = 12'd1500;
		gear_us = 12'd1500;
		now_ms = '0;
		veh = 5'b00010;
		stop_ms = '0;
		motion_ms = '0;
		rev_lock = 1'b0;
		esc_mode_cfg = MODE_CRAWLER;
		park_s_cfg = '0;
		stick = 0;
		run_left = 0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The registers are rewritten whenever a row asks
		// for a different setting, and only after the pipeline has drained.
		foreach (script[i]) begin
			if (script[i].mode != esc_mode_cfg || script[i].park_s != park_s_cfg) begin
				drain();
				apply_setting(script[i].mode, script[i].park_s);
			end
			send_word(script[i].thr, script[i].ste, script[i].gear, script[i].now,
				script[i].typed, script[i].flags);
		end

		// Random part. Each phase runs under its own register setting. The
		// stick moves in runs of forward, neutral and back pushes, with time
		// advancing in realistic steps. Some steps are long enough to reach
		// the drag brake and park limits. Some jumps reach the longest timeout.
		// About one word in ten is noise over the full field ranges.
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			apply_setting(mode_plan[phase], park_plan[phase]);
			// One phase starts just short of the timestamp wrap.
			clock_ms = (phase == 2) ? 32'hFFFF_F000 : $urandom();
			if (phase == 4)
				hold_req = 60;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (i % 30 == 0)
					idle_on = (phase == 4 && i == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
				if (run_left == 0) begin
					stick = $urandom_range(0, 2);
					run_left = $urandom_range(1, 8);
				end
				run_left--;
				case (stick)
					0: thr = 12'($urandom_range(1450, 1550));
					1: thr = 12'($urandom_range(1551, 2100));
					default: thr = 12'($urandom_range(900, 1449));
				endcase
				ste = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(1450, 1550))
					: 12'($urandom_range(1000, 2000));
				gear = 12'($urandom_range(1000, 2000));
				r = $urandom_range(0, 99);
				if (r < 2)
					clock_ms = $urandom();
				else if (r < 5)
					clock_ms += $urandom_range(0, 70_000_000);
				else if (r < 30)
					clock_ms += $urandom_range(500, 4000);
				else
					clock_ms += $urandom_range(0, 400);
				if ($urandom_range(0, 9) == 0) begin
					thr = 12'($urandom_range(0, 4095));
					ste = 12'($urandom_range(0, 4095));
					gear = 12'($urandom_range(0, 4095));
				end
				send_word(thr, ste, gear, clock_ms, 1'b0, 5'b0);
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Checked %0d flag words out of %0d words sent.", words_checked, words_sent);
		$display("The run used all four ESC modes and park timeouts from 0 to 65535 s.");
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rcds_pkg.sv
rtl/rcds_update.sv
rtl/rc_drive_state_tracker.sv
bench/tb_rc_drive_state_tracker.sv
